### hdl/dcsc_pkg.sv
// package for the dma channel start control block
// types, register codes and field constants shared by the sequencer, output stage, top and testbench; no dependencies
`default_nettype none

package dcsc_pkg;

  localparam int unsigned NUM_CHANNELS_DEF = 10;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned CNT_W = 17;
  localparam int unsigned CHAN_W = 4;
  localparam int unsigned SADR_W = 14;
  localparam int unsigned HALF_W = 16;

  localparam int unsigned STR_BIT = 8;
  localparam int unsigned MOD_LO = 2;
  localparam int unsigned MOD_HI = 3;
  localparam int unsigned DMAE_BIT = 0;
  localparam int unsigned SUSPEND_BIT = 16;

  localparam logic [1:0] MOD_NORMAL = 2'b00;
  localparam logic [1:0] MOD_BAD = 2'b11;

  localparam logic [DATA_W-1:0] MADR_SPR_MASK = 32'h7FFF_FFFF;
  localparam logic [SADR_W-1:0] SADR_MASK = 14'h3FF0;
  localparam logic [CNT_W-1:0] CNT_FULL = 17'h1_0000;

  typedef enum logic [1:0] {
    ACT_READ,
    ACT_WRITE,
    ACT_FINISH,
    ACT_NONE
  } action_t;

  typedef enum logic [2:0] {
    REG_CHCR,
    REG_QWC,
    REG_MADR,
    REG_SADR,
    REG_CTRL,
    REG_STAT,
    REG_ENABLE,
    REG_NONE
  } reg_kind_t;

  typedef enum logic [1:0] {
    EV_DONE,
    EV_START,
    EV_STOP
  } event_kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RMW,
    ST_EXEC,
    ST_EVT,
    ST_DONE,
    ST_SWP_RD,
    ST_SWP_CHK
  } state_t;

  typedef struct packed {
    logic [DATA_W-1:0] ctl;
    logic [CNT_W-1:0]  cnt;
    logic [DATA_W-1:0] adr;
  } entry_t;

  typedef struct packed {
    event_kind_t       kind;
    logic [CHAN_W-1:0] chan;
    logic [DATA_W-1:0] data;
    logic              last;
  } word_t;

endpackage

`default_nettype wire

### hdl/dcsc_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module dcsc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

### hdl/dcsc_obuf.sv
// output register stage of the result channel
// depends on dcsc_pkg
`default_nettype none

module dcsc_obuf (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        push_valid,
  input  wire dcsc_pkg::word_t             push_word,
  output logic                             push_ready,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [1:0]                       out_event_kind,
  output logic [dcsc_pkg::CHAN_W-1:0]      out_event_channel,
  output logic [dcsc_pkg::DATA_W-1:0]      out_read_data,
  output logic                             out_last
);

  logic            valid_r;
  logic            valid_nxt;
  dcsc_pkg::word_t word_r;

  assign push_ready = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (push_valid && push_ready) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_valid && push_ready) begin
      word_r <= push_word;
    end
  end

  assign out_valid         = valid_r;
  assign out_event_kind    = 2'(word_r.kind);
  assign out_event_channel = word_r.chan;
  assign out_read_data     = word_r.data;
  assign out_last          = word_r.last;

endmodule

`default_nettype wire

### hdl/dcsc_ctrl.sv
// access sequencer: decodes a word, read-modify-writes the channel ram,
// keeps global registers and the start queue; depends on dcsc_pkg
`default_nettype none

module dcsc_ctrl #(
  parameter int unsigned NUM_CHANNELS = dcsc_pkg::NUM_CHANNELS_DEF,
  localparam int unsigned AW = $clog2(NUM_CHANNELS),
  localparam int unsigned EW = $bits(dcsc_pkg::entry_t)
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [1:0]                    in_action,
  input  wire logic [2:0]                    in_reg_kind,
  input  wire logic [dcsc_pkg::CHAN_W-1:0]   in_channel,
  input  wire logic [dcsc_pkg::DATA_W-1:0]   in_write_data,
  output logic                               ram_we,
  output logic [AW-1:0]                      ram_wr_addr,
  output logic [EW-1:0]                      ram_wr_data,
  output logic                               ram_rd_en,
  output logic [AW-1:0]                      ram_rd_addr,
  input  wire logic [EW-1:0]                 ram_rd_data,
  output logic                               push_valid,
  output dcsc_pkg::word_t                    push_word,
  input  wire logic                          push_ready
);

  localparam logic [dcsc_pkg::CHAN_W:0]   NCH  = (dcsc_pkg::CHAN_W+1)'(NUM_CHANNELS);
  localparam logic [dcsc_pkg::CHAN_W-1:0] SPR0 = dcsc_pkg::CHAN_W'(NUM_CHANNELS - 2);
  localparam logic [dcsc_pkg::CHAN_W-1:0] SPR1 = dcsc_pkg::CHAN_W'(NUM_CHANNELS - 1);
  localparam logic [AW-1:0]               LAST = AW'(NUM_CHANNELS - 1);

  dcsc_pkg::state_t      state_r, state_nxt;
  dcsc_pkg::action_t     act_r;
  dcsc_pkg::reg_kind_t   kind_r;
  logic [dcsc_pkg::CHAN_W-1:0] ch_r;
  logic [dcsc_pkg::DATA_W-1:0] wdata_r;
  logic                  rd_vld_r, rd_vld_nxt;
  logic [NUM_CHANNELS-1:0] valid_r, valid_nxt;
  logic [NUM_CHANNELS-1:0] pend_r, pend_nxt;
  logic [dcsc_pkg::DATA_W-1:0] ctrl_r, ctrl_nxt;
  logic [dcsc_pkg::DATA_W-1:0] stat_r, stat_nxt;
  logic [dcsc_pkg::DATA_W-1:0] enab_r, enab_nxt;
  logic [dcsc_pkg::SADR_W-1:0] sadr_r [2];
  logic [dcsc_pkg::SADR_W-1:0] sadr_nxt [2];
  logic [AW-1:0]         idx_r, idx_nxt;
  dcsc_pkg::event_kind_t evt_r, evt_nxt;
  logic [dcsc_pkg::DATA_W-1:0] rdata_r, rdata_nxt;

  dcsc_pkg::action_t     in_act;
  dcsc_pkg::reg_kind_t   in_kind;
  logic                  in_ok;
  logic                  needs_entry;
  logic                  accept;
  logic                  ch_ok;
  logic                  spr;
  logic                  slot;
  logic [AW-1:0]         chi;
  logic                  may_run;
  dcsc_pkg::entry_t      ent;
  dcsc_pkg::entry_t      ent_new;
  logic                  has_evt;
  logic                  go_sweep;
  logic                  hit;
  logic [dcsc_pkg::DATA_W-1:0] rd_val;

  assign in_act  = dcsc_pkg::action_t'(in_action);
  assign in_kind = dcsc_pkg::reg_kind_t'(in_reg_kind);
  assign in_ok   = {1'b0, in_channel} < NCH;
  assign needs_entry = in_ok &&
    (((in_act == dcsc_pkg::ACT_READ || in_act == dcsc_pkg::ACT_WRITE) &&
      (in_kind == dcsc_pkg::REG_CHCR || in_kind == dcsc_pkg::REG_QWC ||
       in_kind == dcsc_pkg::REG_MADR)) ||
     in_act == dcsc_pkg::ACT_FINISH);

  assign in_ready = (state_r == dcsc_pkg::ST_IDLE);
  assign accept   = in_valid && in_ready;

  assign ch_ok   = {1'b0, ch_r} < NCH;
  assign spr     = ch_ok && (ch_r == SPR0 || ch_r == SPR1);
  assign slot    = (ch_r == SPR1);
  assign chi     = ch_r[AW-1:0];
  assign may_run = ctrl_r[dcsc_pkg::DMAE_BIT] && !enab_r[dcsc_pkg::SUSPEND_BIT];
  assign ent     = rd_vld_r ? dcsc_pkg::entry_t'(ram_rd_data) : '0;
  assign hit     = pend_r[idx_r] && ent.ctl[dcsc_pkg::STR_BIT] && may_run;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      dcsc_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = needs_entry ? dcsc_pkg::ST_RMW : dcsc_pkg::ST_EXEC;
        end
      end
      dcsc_pkg::ST_RMW: begin
        if (has_evt) begin
          state_nxt = dcsc_pkg::ST_EVT;
        end else begin
          state_nxt = push_ready ? dcsc_pkg::ST_IDLE : dcsc_pkg::ST_DONE;
        end
      end
      dcsc_pkg::ST_EXEC: begin
        if (go_sweep) begin
          state_nxt = dcsc_pkg::ST_SWP_RD;
        end else begin
          state_nxt = push_ready ? dcsc_pkg::ST_IDLE : dcsc_pkg::ST_DONE;
        end
      end
      dcsc_pkg::ST_EVT: begin
        if (push_ready) begin
          state_nxt = dcsc_pkg::ST_DONE;
        end
      end
      dcsc_pkg::ST_DONE: begin
        if (push_ready) begin
          state_nxt = dcsc_pkg::ST_IDLE;
        end
      end
      dcsc_pkg::ST_SWP_RD: begin
        state_nxt = dcsc_pkg::ST_SWP_CHK;
      end
      dcsc_pkg::ST_SWP_CHK: begin
        if (!hit || push_ready) begin
          state_nxt = (idx_r == LAST) ? dcsc_pkg::ST_DONE : dcsc_pkg::ST_SWP_RD;
        end
      end
      default: state_nxt = dcsc_pkg::ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    logic [dcsc_pkg::DATA_W-1:0] v;
    v           = wdata_r;
    ent_new     = ent;
    rd_val      = '0;
    has_evt     = 1'b0;
    go_sweep    = 1'b0;
    evt_nxt     = evt_r;
    rdata_nxt   = rdata_r;
    rd_vld_nxt  = rd_vld_r;
    valid_nxt   = valid_r;
    pend_nxt    = pend_r;
    ctrl_nxt    = ctrl_r;
    stat_nxt    = stat_r;
    enab_nxt    = enab_r;
    sadr_nxt    = sadr_r;
    idx_nxt     = idx_r;
    ram_rd_en   = 1'b0;
    ram_rd_addr = in_channel[AW-1:0];
    ram_we      = 1'b0;
    ram_wr_addr = chi;
    push_valid  = 1'b0;
    push_word   = '{kind: dcsc_pkg::EV_DONE, chan: '0, data: '0, last: 1'b1};

    unique case (state_r)
      dcsc_pkg::ST_IDLE: begin
        if (accept) begin
          ram_rd_en  = needs_entry;
          rd_vld_nxt = in_ok ? valid_r[in_channel[AW-1:0]] : 1'b0;
        end
      end
      dcsc_pkg::ST_RMW: begin
        case (act_r)
          dcsc_pkg::ACT_READ: begin
            case (kind_r)
              dcsc_pkg::REG_CHCR: rd_val = ent.ctl;
              dcsc_pkg::REG_QWC:  rd_val = dcsc_pkg::DATA_W'(ent.cnt);
              dcsc_pkg::REG_MADR: rd_val = ent.adr;
              default:            rd_val = '0;
            endcase
          end
          dcsc_pkg::ACT_WRITE: begin
            case (kind_r)
              dcsc_pkg::REG_CHCR: begin
                if (ent.ctl[dcsc_pkg::STR_BIT]) begin
                  if (!wdata_r[dcsc_pkg::STR_BIT]) begin
                    ent_new.ctl[dcsc_pkg::STR_BIT] = 1'b0;
                    pend_nxt[chi] = 1'b0;
                    has_evt = 1'b1;
                    evt_nxt = dcsc_pkg::EV_STOP;
                  end
                end else begin
                  if (v[dcsc_pkg::MOD_HI:dcsc_pkg::MOD_LO] == dcsc_pkg::MOD_BAD) begin
                    v[dcsc_pkg::MOD_HI] = 1'b0;
                  end
                  ent_new.ctl = v;
                  if (v[dcsc_pkg::STR_BIT]) begin
                    if (v[dcsc_pkg::MOD_HI:dcsc_pkg::MOD_LO] == dcsc_pkg::MOD_NORMAL &&
                        ent.cnt == '0) begin
                      ent_new.cnt = dcsc_pkg::CNT_FULL;
                    end
                    if (may_run) begin
                      has_evt = 1'b1;
                      evt_nxt = dcsc_pkg::EV_START;
                    end else begin
                      pend_nxt[chi] = 1'b1;
                    end
                  end
                end
              end
              dcsc_pkg::REG_QWC: begin
                ent_new.cnt = dcsc_pkg::CNT_W'(wdata_r[dcsc_pkg::HALF_W-1:0]);
              end
              dcsc_pkg::REG_MADR: begin
                ent_new.adr = spr ? (wdata_r & dcsc_pkg::MADR_SPR_MASK) : wdata_r;
              end
              default: ;
            endcase
          end
          dcsc_pkg::ACT_FINISH: begin
            ent_new.ctl[dcsc_pkg::STR_BIT] = 1'b0;
          end
          default: ;
        endcase
        ram_we         = 1'b1;
        valid_nxt[chi] = 1'b1;
        rdata_nxt      = rd_val;
        if (!has_evt) begin
          push_valid     = push_ready;
          push_word.data = rd_val;
        end
      end
      dcsc_pkg::ST_EXEC: begin
        case (act_r)
          dcsc_pkg::ACT_READ: begin
            case (kind_r)
              dcsc_pkg::REG_SADR:   rd_val = spr ? dcsc_pkg::DATA_W'(sadr_r[slot]) : '0;
              dcsc_pkg::REG_CTRL:   rd_val = ctrl_r;
              dcsc_pkg::REG_STAT:   rd_val = stat_r;
              dcsc_pkg::REG_ENABLE: rd_val = enab_r;
              default:              rd_val = '0;
            endcase
          end
          dcsc_pkg::ACT_WRITE: begin
            case (kind_r)
              dcsc_pkg::REG_SADR: begin
                if (spr) begin
                  sadr_nxt[slot] = wdata_r[dcsc_pkg::SADR_W-1:0] & dcsc_pkg::SADR_MASK;
                end
              end
              dcsc_pkg::REG_CTRL: begin
                ctrl_nxt = wdata_r;
                go_sweep = !ctrl_r[dcsc_pkg::DMAE_BIT] && wdata_r[dcsc_pkg::DMAE_BIT] &&
                           (pend_r != '0);
              end
              dcsc_pkg::REG_STAT: begin
                stat_nxt = {stat_r[dcsc_pkg::DATA_W-1:dcsc_pkg::HALF_W] ^
                            wdata_r[dcsc_pkg::DATA_W-1:dcsc_pkg::HALF_W],
                            stat_r[dcsc_pkg::HALF_W-1:0] & ~wdata_r[dcsc_pkg::HALF_W-1:0]};
              end
              dcsc_pkg::REG_ENABLE: begin
                enab_nxt = wdata_r;
                go_sweep = enab_r[dcsc_pkg::SUSPEND_BIT] && !wdata_r[dcsc_pkg::SUSPEND_BIT] &&
                           (pend_r != '0);
              end
              default: ;
            endcase
          end
          default: ;
        endcase
        rdata_nxt = rd_val;
        idx_nxt   = '0;
        if (!go_sweep) begin
          push_valid     = push_ready;
          push_word.data = rd_val;
        end
      end
      dcsc_pkg::ST_EVT: begin
        push_valid = push_ready;
        push_word  = '{kind: evt_r, chan: ch_r, data: '0, last: 1'b0};
      end
      dcsc_pkg::ST_DONE: begin
        push_valid     = push_ready;
        push_word.data = rdata_r;
      end
      dcsc_pkg::ST_SWP_RD: begin
        ram_rd_en   = 1'b1;
        ram_rd_addr = idx_r;
        rd_vld_nxt  = valid_r[idx_r];
      end
      dcsc_pkg::ST_SWP_CHK: begin
        push_word = '{kind: dcsc_pkg::EV_START, chan: dcsc_pkg::CHAN_W'(idx_r),
                      data: '0, last: 1'b0};
        if (hit) begin
          push_valid = push_ready;
          if (push_ready) begin
            pend_nxt[idx_r] = 1'b0;
          end
        end
        if (!hit || push_ready) begin
          idx_nxt = idx_r + AW'(1);
        end
      end
      default: ;
    endcase
  end

  assign ram_wr_data = EW'(ent_new);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dcsc_pkg::ST_IDLE;
      valid_r <= '0;
      pend_r  <= '0;
      ctrl_r  <= '0;
      stat_r  <= '0;
      enab_r  <= '0;
      sadr_r  <= '{default: '0};
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
      pend_r  <= pend_nxt;
      ctrl_r  <= ctrl_nxt;
      stat_r  <= stat_nxt;
      enab_r  <= enab_nxt;
      sadr_r  <= sadr_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      act_r   <= in_act;
      kind_r  <= in_kind;
      ch_r    <= in_channel;
      wdata_r <= in_write_data;
    end
    rd_vld_r <= rd_vld_nxt;
    evt_r    <= evt_nxt;
    rdata_r  <= rdata_nxt;
  end

  a_push_ready: assert property (@(posedge clk) disable iff (!rst_n)
    push_valid |-> push_ready)
    else $error("word pushed into a full output stage");

  a_accept_route: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == dcsc_pkg::ST_RMW || state_r == dcsc_pkg::ST_EXEC))
    else $error("accepted word not routed to ram or global stage");

  a_sweep_start: assert property (@(posedge clk) disable iff (!rst_n)
    (push_valid && state_r == dcsc_pkg::ST_SWP_CHK) |->
      (may_run && push_word.kind == dcsc_pkg::EV_START && !push_word.last))
    else $error("queued start released while controller may not run");

  a_no_write_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == dcsc_pkg::ST_SWP_RD || state_r == dcsc_pkg::ST_SWP_CHK) |-> !ram_we)
    else $error("channel ram written during queue release");

endmodule

`default_nettype wire

### hdl/dma_channel_start_control_top.sv
// top level of the dma channel start control block
// instantiates dcsc_ctrl, dcsc_ram and dcsc_obuf; depends on dcsc_pkg
//
// Usage: one input word per bus access (read, write or channel finished).
// Each access produces zero or more start/stop event words followed by one
// completion word with last set; a read completion carries the register value.
// Per-channel control, count and address live in one ram, read-modify-written.
// Sequence: with no event the completion is pushed to the output register
// from RMW or EXEC (from DONE if the output stage is full); with a start or
// stop event the event is pushed from EVT and the completion from DONE.
// A write that releases queued starts walks the channel ram, one SWP_RD and
// one SWP_CHK state per channel, then pushes its completion from DONE.
// The next access is accepted once the sequencer is back in IDLE.
// One access is in work at a time; in_ready is high only between accesses.
// The output register lets a new access be accepted while the last completion
// still waits; when out_ready stays low the sequencer holds its event or
// completion and in_ready stays low. Reset clears the state, the global
// registers, the start queue and the per-entry valid bits, so unwritten
// channel entries read as zero; no clearing pass is needed.
`default_nettype none

module dma_channel_start_control_top #(
  parameter int unsigned NUM_CHANNELS = dcsc_pkg::NUM_CHANNELS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [1:0]                  in_action,
  input  wire logic [2:0]                  in_reg_kind,
  input  wire logic [dcsc_pkg::CHAN_W-1:0] in_channel,
  input  wire logic [dcsc_pkg::DATA_W-1:0] in_write_data,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [1:0]                       out_event_kind,
  output logic [dcsc_pkg::CHAN_W-1:0]      out_event_channel,
  output logic [dcsc_pkg::DATA_W-1:0]      out_read_data,
  output logic                             out_last
);

  localparam int unsigned AW = $clog2(NUM_CHANNELS);
  localparam int unsigned EW = $bits(dcsc_pkg::entry_t);

  logic            ram_we;
  logic [AW-1:0]   ram_wr_addr;
  logic [EW-1:0]   ram_wr_data;
  logic            ram_rd_en;
  logic [AW-1:0]   ram_rd_addr;
  logic [EW-1:0]   ram_rd_data;
  logic            push_valid;
  logic            push_ready;
  dcsc_pkg::word_t push_word;

  dcsc_ctrl #(
    .NUM_CHANNELS(NUM_CHANNELS)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_action    (in_action),
    .in_reg_kind  (in_reg_kind),
    .in_channel   (in_channel),
    .in_write_data(in_write_data),
    .ram_we       (ram_we),
    .ram_wr_addr  (ram_wr_addr),
    .ram_wr_data  (ram_wr_data),
    .ram_rd_en    (ram_rd_en),
    .ram_rd_addr  (ram_rd_addr),
    .ram_rd_data  (ram_rd_data),
    .push_valid   (push_valid),
    .push_word    (push_word),
    .push_ready   (push_ready)
  );

  dcsc_ram #(
    .WIDTH(EW),
    .DEPTH(NUM_CHANNELS)
  ) u_ram (
    .clk    (clk),
    .we     (ram_we),
    .wr_addr(ram_wr_addr),
    .wr_data(ram_wr_data),
    .rd_en  (ram_rd_en),
    .rd_addr(ram_rd_addr),
    .rd_data(ram_rd_data)
  );

  dcsc_obuf u_obuf (
    .clk              (clk),
    .rst_n            (rst_n),
    .push_valid       (push_valid),
    .push_word        (push_word),
    .push_ready       (push_ready),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_event_kind   (out_event_kind),
    .out_event_channel(out_event_channel),
    .out_read_data    (out_read_data),
    .out_last         (out_last)
  );

endmodule

`default_nettype wire

### tb/tb_dma_channel_start_control_top.sv
// self-checking testbench for dma_channel_start_control_top: directed and random bus accesses,
// a scoreboard class predicts start, stop and completion words and checks them in order
// depends on dcsc_pkg and the block's rtl
module tb_dma_channel_start_control_top;
  import dcsc_pkg::*;

  localparam int NCH = NUM_CHANNELS_DEF;
  localparam int N_ITEMS = 200;
  localparam int HOLD_CYCLES = 150;

  class dma_reg_scoreboard;
    logic [DATA_W-1:0] chan_ctl [NCH];
    logic [CNT_W-1:0]  chan_cnt [NCH];
    logic [DATA_W-1:0] chan_adr [NCH];
    logic [SADR_W-1:0] spr_sadr [2];
    logic [DATA_W-1:0] ctrl_w;
    logic [DATA_W-1:0] stat_w;
    logic [DATA_W-1:0] enab_w;
    logic [NCH-1:0]    queued;
    word_t             expected_words[$];
    int                mismatches;

    function new();
      for (int i = 0; i < NCH; i++) begin
        chan_ctl[i] = '0;
        chan_cnt[i] = '0;
        chan_adr[i] = '0;
      end
      spr_sadr[0] = '0;
      spr_sadr[1] = '0;
      ctrl_w = '0;
      stat_w = '0;
      enab_w = '0;
      queued = '0;
      mismatches = 0;
    endfunction

    function void add_word(event_kind_t k, logic [CHAN_W-1:0] ch, logic [DATA_W-1:0] d,
                           logic l);
      word_t w;
      w.kind = k;
      w.chan = ch;
      w.data = d;
      w.last = l;
      expected_words.push_back(w);
    endfunction

    function bit may_run();
      return ctrl_w[DMAE_BIT] && !enab_w[SUSPEND_BIT];
    endfunction

    function void release_queue();
      for (int i = 0; i < NCH; i++) begin
        if (queued[i] && chan_ctl[i][STR_BIT] && may_run()) begin
          queued[i] = 1'b0;
          add_word(EV_START, CHAN_W'(i), '0, 1'b0);
        end
      end
    endfunction

    function void write_chcr(int ch, logic [DATA_W-1:0] v);
      logic [DATA_W-1:0] nv;
      nv = v;
      if (chan_ctl[ch][STR_BIT]) begin
        if (!nv[STR_BIT]) begin
          chan_ctl[ch][STR_BIT] = 1'b0;
          queued[ch] = 1'b0;
          add_word(EV_STOP, CHAN_W'(ch), '0, 1'b0);
        end
        return;
      end
      if (nv[MOD_HI:MOD_LO] == MOD_BAD) nv[MOD_HI] = 1'b0;
      chan_ctl[ch] = nv;
      if (!nv[STR_BIT]) return;
      if (nv[MOD_HI:MOD_LO] == MOD_NORMAL && chan_cnt[ch] == '0) chan_cnt[ch] = CNT_FULL;
      if (may_run()) add_word(EV_START, CHAN_W'(ch), '0, 1'b0);
      else queued[ch] = 1'b1;
    endfunction

    function void note_access(action_t a, reg_kind_t k, logic [CHAN_W-1:0] ch,
                              logic [DATA_W-1:0] v);
      bit ch_ok;
      int slot;
      logic [DATA_W-1:0] rd;
      logic old_bit;
      ch_ok = ch < NCH;
      slot = -1;
      if (ch_ok && ch == NCH - 2) slot = 0;
      else if (ch_ok && ch == NCH - 1) slot = 1;
      rd = '0;
      case (a)
        ACT_READ: begin
          case (k)
            REG_CHCR: if (ch_ok) rd = chan_ctl[ch];
            REG_QWC: if (ch_ok) rd = DATA_W'(chan_cnt[ch]);
            REG_MADR: if (ch_ok) rd = chan_adr[ch];
            REG_SADR: if (slot >= 0) rd = DATA_W'(spr_sadr[slot]);
            REG_CTRL: rd = ctrl_w;
            REG_STAT: rd = stat_w;
            REG_ENABLE: rd = enab_w;
            default: rd = '0;
          endcase
        end
        ACT_WRITE: begin
          case (k)
            REG_CHCR: if (ch_ok) write_chcr(int'(ch), v);
            REG_QWC: if (ch_ok) chan_cnt[ch] = CNT_W'(v[HALF_W-1:0]);
            REG_MADR: if (ch_ok) chan_adr[ch] = (slot >= 0) ? (v & MADR_SPR_MASK) : v;
            REG_SADR: if (slot >= 0) spr_sadr[slot] = v[SADR_W-1:0] & SADR_MASK;
            REG_CTRL: begin
              old_bit = ctrl_w[DMAE_BIT];
              ctrl_w = v;
              if (!old_bit && v[DMAE_BIT] && queued != '0) release_queue();
            end
            REG_STAT: begin
              stat_w = {stat_w[DATA_W-1:HALF_W] ^ v[DATA_W-1:HALF_W],
                        stat_w[HALF_W-1:0] & ~v[HALF_W-1:0]};
            end
            REG_ENABLE: begin
              old_bit = enab_w[SUSPEND_BIT];
              enab_w = v;
              if (old_bit && !v[SUSPEND_BIT] && queued != '0) release_queue();
            end
            default: ;
          endcase
        end
        ACT_FINISH: if (ch_ok) chan_ctl[ch][STR_BIT] = 1'b0;
        default: ;
      endcase
      add_word(EV_DONE, '0, rd, 1'b1);
    endfunction

    function void check_word(logic [1:0] k, logic [CHAN_W-1:0] ch, logic [DATA_W-1:0] d,
                             logic l);
      word_t exp_w;
      if (expected_words.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected word kind %0d ch %0d data %h last %0b",
                 $time, k, ch, d, l);
        return;
      end
      exp_w = expected_words.pop_front();
      if (k !== exp_w.kind || ch !== exp_w.chan || d !== exp_w.data || l !== exp_w.last) begin
        mismatches++;
        $display("%0t: mismatch expected kind %0d ch %0d data %h last %0b", $time,
                 exp_w.kind, exp_w.chan, exp_w.data, exp_w.last);
        $display("%0t:          actual   kind %0d ch %0d data %h last %0b", $time,
                 k, ch, d, l);
      end
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic [1:0]        in_action;
  logic [2:0]        in_reg_kind;
  logic [CHAN_W-1:0] in_channel;
  logic [DATA_W-1:0] in_write_data;
  logic              out_valid;
  logic              out_ready;
  logic [1:0]        out_event_kind;
  logic [CHAN_W-1:0] out_event_channel;
  logic [DATA_W-1:0] out_read_data;
  logic              out_last;

  dma_reg_scoreboard sb = new();
  int accesses_sent = 0;
  bit quiet = 1'b0;
  bit hold_req = 1'b0;

  dma_channel_start_control_top DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_action(in_action),
    .in_reg_kind(in_reg_kind),
    .in_channel(in_channel),
    .in_write_data(in_write_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_event_kind(out_event_kind),
    .out_event_channel(out_event_channel),
    .out_read_data(out_read_data),
    .out_last(out_last)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("tb_dma_channel_start_control_top: errors");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_word(out_event_kind, out_event_channel, out_read_data, out_last);
  end

  // receiver: short random stalls, and a long hold-off whenever the access count reaches 60, to back up the block
  initial begin
    int stall_left;
    stall_left = 0;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (stall_left == 0 && hold_req) begin
        hold_req = 1'b0;
        stall_left = HOLD_CYCLES;
      end else if (stall_left == 0 && !quiet && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 3);
      end
      if (stall_left > 0) begin
        out_ready = 1'b0;
        stall_left--;
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  // called and returns at a falling edge
  task automatic bus_access(action_t a, reg_kind_t k, logic [CHAN_W-1:0] ch,
                            logic [DATA_W-1:0] d);
    if (!quiet && $urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) @(negedge clk);
    in_valid = 1'b1;
    in_action = a;
    in_reg_kind = k;
    in_channel = ch;
    in_write_data = d;
    do @(posedge clk); while (!in_ready);
    sb.note_access(a, k, ch, d);
    if (a != ACT_NONE) accesses_sent++;
    if (accesses_sent == 60) hold_req = 1'b1;
    if (accesses_sent >= N_ITEMS - 40) quiet = 1'b1;
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // park starts while blocked, then release them through dmae or suspend
  task automatic queued_start_burst(int n, bit every_channel);
    bit via_suspend;
    logic [DATA_W-1:0] v;
    int ch;
    via_suspend = 1'($urandom_range(0, 1));
    v = $urandom;
    if (via_suspend) begin
      v[DMAE_BIT] = 1'b1;
      bus_access(ACT_WRITE, REG_CTRL, '0, v);
      v = $urandom;
      v[SUSPEND_BIT] = 1'b1;
      bus_access(ACT_WRITE, REG_ENABLE, '0, v);
    end else begin
      v[DMAE_BIT] = 1'b0;
      bus_access(ACT_WRITE, REG_CTRL, '0, v);
    end
    for (int j = 0; j < n; j++) begin
      ch = every_channel ? j : $urandom_range(0, NCH - 1);
      if (every_channel || $urandom_range(0, 1))
        bus_access(ACT_FINISH, reg_kind_t'($urandom_range(0, 7)), CHAN_W'(ch), $urandom);
      if ($urandom_range(0, 3) == 0)
        bus_access(ACT_WRITE, REG_QWC, CHAN_W'(ch), $urandom_range(0, 1) ? 0 : $urandom);
      v = $urandom;
      v[STR_BIT] = every_channel || $urandom_range(0, 5) != 0;
      bus_access(ACT_WRITE, REG_CHCR, CHAN_W'(ch), v);
    end
    v = $urandom;
    if (via_suspend) begin
      v[SUSPEND_BIT] = !every_channel && $urandom_range(0, 5) == 0;
      bus_access(ACT_WRITE, REG_ENABLE, '0, v);
    end else begin
      v[DMAE_BIT] = every_channel || $urandom_range(0, 5) != 0;
      bus_access(ACT_WRITE, REG_CTRL, '0, v);
    end
    repeat ($urandom_range(0, 3))
      bus_access(ACT_FINISH, reg_kind_t'($urandom_range(0, 7)),
                 CHAN_W'($urandom_range(0, NCH - 1)), $urandom);
  endtask

  task automatic random_access();
    int pick;
    action_t a;
    logic [CHAN_W-1:0] ch;
    pick = $urandom_range(0, 99);
    if (pick < 35) a = ACT_READ;
    else if (pick < 80) a = ACT_WRITE;
    else if (pick < 95) a = ACT_FINISH;
    else a = ACT_NONE;
    if ($urandom_range(0, 6) == 0) ch = CHAN_W'($urandom_range(0, 15));
    else ch = CHAN_W'($urandom_range(0, NCH - 1));
    bus_access(a, reg_kind_t'($urandom_range(0, 7)), ch, $urandom);
  endtask

  initial begin
    int drain;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_action = ACT_READ;
    in_reg_kind = REG_CHCR;
    in_channel = '0;
    in_write_data = '0;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    bus_access(ACT_READ, REG_CHCR, 4'd0, '0);
    bus_access(ACT_WRITE, REG_CHCR, 4'd0, 32'h0000_0100);
    bus_access(ACT_READ, REG_QWC, 4'd0, '0);
    bus_access(ACT_WRITE, REG_ENABLE, '0, 32'hFFFF_FFFF);
    bus_access(ACT_WRITE, REG_CTRL, '0, 32'h0000_0001);
    bus_access(ACT_WRITE, REG_CHCR, 4'd1, 32'h0000_010C);
    bus_access(ACT_WRITE, REG_CHCR, 4'd2, 32'h0000_0104);
    bus_access(ACT_FINISH, REG_CHCR, 4'd2, '0);
    bus_access(ACT_WRITE, REG_ENABLE, '0, 32'h0000_0000);
    bus_access(ACT_WRITE, REG_CHCR, 4'd4, 32'h0000_0100);
    bus_access(ACT_WRITE, REG_CHCR, 4'd0, 32'hFFFF_FFFF);
    bus_access(ACT_WRITE, REG_CHCR, 4'd0, 32'h0000_0000);
    bus_access(ACT_FINISH, REG_CHCR, 4'd1, '0);
    bus_access(ACT_READ, REG_CHCR, 4'd1, '0);
    bus_access(ACT_WRITE, REG_QWC, 4'd3, 32'hFFFF_FFFF);
    bus_access(ACT_WRITE, REG_MADR, CHAN_W'(NCH - 2), 32'hFFFF_FFFF);
    bus_access(ACT_WRITE, REG_SADR, CHAN_W'(NCH - 1), 32'hFFFF_FFFF);
    bus_access(ACT_WRITE, REG_SADR, 4'd3, 32'hFFFF_FFFF);
    bus_access(ACT_READ, REG_SADR, CHAN_W'(NCH - 1), '0);
    bus_access(ACT_WRITE, REG_STAT, '0, 32'hFFFF_FFFF);
    bus_access(ACT_WRITE, REG_STAT, '0, 32'h5555_AAAA);
    bus_access(ACT_READ, REG_STAT, '0, '0);
    bus_access(ACT_WRITE, REG_CHCR, 4'd15, 32'h0000_0100);
    bus_access(ACT_FINISH, REG_CHCR, CHAN_W'(NCH), '0);
    bus_access(ACT_READ, REG_NONE, 4'd0, '0);
    bus_access(ACT_NONE, REG_CTRL, 4'd0, 32'hFFFF_FFFF);

    queued_start_burst(NCH, 1'b1);
    while (accesses_sent < N_ITEMS) begin
      if ($urandom_range(0, 2) == 0) queued_start_burst($urandom_range(1, NCH), 1'b0);
      else random_access();
    end

    drain = 0;
    while (sb.expected_words.size() != 0 && drain < 5000) begin
      @(posedge clk);
      drain++;
    end
    if (sb.expected_words.size() != 0) begin
      $display("tb_dma_channel_start_control_top: errors");
      $finish;
    end else begin
      repeat (3 * NCH + 10) @(posedge clk);
      if (sb.mismatches == 0) $display("tb_dma_channel_start_control_top: clean");
      else $display("tb_dma_channel_start_control_top: errors");
      $finish;
    end
  end
endmodule
